### design/curtain_pkg.sv
// ----------------------------------------------------------------------------
// Curtain relay controller package
// Mode codes, relay patterns, register map and reset values shared by the
// curtain relay controller, plus the helper that sizes a blocking wait.
// ----------------------------------------------------------------------------
package curtain_pkg;

    // Operating modes as shown on the mode_code output.
    localparam logic [2:0] MODE_WAIT       = 3'd0;
    localparam logic [2:0] MODE_OPEN       = 3'd1;
    localparam logic [2:0] MODE_CLOSE      = 3'd2;
    localparam logic [2:0] MODE_FULL_OPEN  = 3'd3;
    localparam logic [2:0] MODE_FULL_CLOSE = 3'd4;
    localparam logic [2:0] MODE_EXT_OPEN   = 3'd5;
    localparam logic [2:0] MODE_EXT_CLOSE  = 3'd6;

    // Relay patterns: bit 0 is relay one, bit 1 is relay two.
    localparam logic [1:0] RELAY_STOP  = 2'b11;
    localparam logic [1:0] RELAY_OPEN  = 2'b10;
    localparam logic [1:0] RELAY_CLOSE = 2'b00;

    // Longest wait the hold countdown can express.
    localparam logic [11:0] HOLD_MAX = 12'hFFF;

    // Register indexes (byte address is four times the index).
    localparam logic [2:0] REG_CONTROL_TIME = 3'd0;
    localparam logic [2:0] REG_ACTION_TIME  = 3'd1;
    localparam logic [2:0] REG_EXT_INVERT   = 3'd2;
    localparam logic [2:0] REG_POLL         = 3'd3;
    localparam logic [2:0] REG_START_HOLD   = 3'd4;
    localparam logic [2:0] REG_STOP_GAP     = 3'd5;
    localparam logic [2:0] REG_FULL_HOLD    = 3'd6;
    localparam logic [2:0] REG_CANCEL_HOLD  = 3'd7;

    // Register reset values.
    localparam logic [15:0] CONTROL_TIME_RST = 16'd3000;
    localparam logic [16:0] ACTION_TIME_RST  = 17'd70000;
    localparam logic        EXT_INVERT_RST   = 1'b1;
    localparam logic [7:0]  POLL_RST         = 8'd20;
    localparam logic [9:0]  START_HOLD_RST   = 10'd200;
    localparam logic [9:0]  STOP_GAP_RST     = 10'd500;
    localparam logic [11:0] FULL_HOLD_RST    = 12'd2000;
    localparam logic [11:0] CANCEL_HOLD_RST  = 12'd1000;

    // Packed input request levels.
    typedef struct packed {
        logic ext_close;
        logic ext_open;
        logic man_close;
        logic man_open;
    } tick_in_t;

    // Hold count for a wait of poll plus extra ticks: one less than the
    // total, limited to the countdown range, zero for an empty wait.
    function automatic logic [11:0] wait_load(input logic [11:0] extra,
                                              input logic [7:0]  poll);
        logic [12:0] total;
        logic [12:0] total_m1;
        begin
            total    = {1'b0, extra} + {5'b0, poll};
            total_m1 = total - 13'd1;
            if (total == 13'd0)
            begin
                wait_load = 12'd0;
            end
            else if (total_m1 > {1'b0, HOLD_MAX})
            begin
                wait_load = HOLD_MAX;
            end
            else
            begin
                wait_load = total_m1[11:0];
            end
        end
    endfunction

endpackage

### design/curtain_relay_controller.sv
// ----------------------------------------------------------------------------
// Curtain relay controller
// Drives the two motor relays from one-millisecond tick requests that carry
// the manual and external input levels.
// ----------------------------------------------------------------------------
// Each request on the input stream is one millisecond tick and yields exactly
// one result in the next cycle, carrying the relay levels and the mode. A new
// tick is taken every clock as long as the result register is empty or being
// drained in the same cycle; the whole tick update (saturating elapsed timer,
// stop gap and hold countdowns, input evaluation) sits in combinational logic
// between the state registers and the result register. There is no clearing
// pass after reset. The user must write configuration registers over the APB
// port only while no tick is in flight; the block does not enforce this.
module curtain_relay_controller #(
    parameter int TIMER_WIDTH = 17
) (
    input  logic        clk,
    input  logic        rst_n,
    // Tick input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] manual_open_level, [1] manual_close_level,
    // [2] external_open_level, [3] external_close_level, [7:4] zero
    input  logic [7:0]  s_axis_tdata,
    // Result output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] relay_one, [1] relay_two, [4:2] mode_code, [7:5] zero
    output logic [7:0]  m_axis_tdata,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Compare width covers both the timer and the 17-bit action limit.
    localparam int CMP_W = (TIMER_WIDTH > 17) ? TIMER_WIDTH : 17;

    // Configuration registers.
    logic [15:0] control_time_reg;
    logic [16:0] action_time_reg;
    logic        ext_invert_reg;
    logic [7:0]  poll_reg;
    logic [9:0]  start_hold_reg;
    logic [9:0]  stop_gap_reg;
    logic [11:0] full_hold_reg;
    logic [11:0] cancel_hold_reg;

    // Controller state.
    logic [2:0]             mode_reg, mode_next;
    logic [TIMER_WIDTH-1:0] elapsed_reg, elapsed_next;
    logic [11:0]            hold_reg, hold_next;
    logic [9:0]             gap_reg, gap_next;
    logic [1:0]             relay_reg, relay_next;

    // Result register.
    logic       out_valid_reg;
    logic [7:0] out_data_reg;

    logic                   cfg_write;
    logic                   accept;
    curtain_pkg::tick_in_t  tick;
    logic [TIMER_WIDTH-1:0] elapsed_inc;
    logic [CMP_W-1:0]       elapsed_cmp;
    logic                   timed_out;
    logic                   held_too_long;
    logic [1:0]             full_drive;

    // Handshake: take a tick whenever the result register can move on.
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign tick          = curtain_pkg::tick_in_t'(s_axis_tdata[3:0]);

    // Configuration write strobe; the port never waits.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_time_reg <= curtain_pkg::CONTROL_TIME_RST;
            action_time_reg  <= curtain_pkg::ACTION_TIME_RST;
            ext_invert_reg   <= curtain_pkg::EXT_INVERT_RST;
            poll_reg         <= curtain_pkg::POLL_RST;
            start_hold_reg   <= curtain_pkg::START_HOLD_RST;
            stop_gap_reg     <= curtain_pkg::STOP_GAP_RST;
            full_hold_reg    <= curtain_pkg::FULL_HOLD_RST;
            cancel_hold_reg  <= curtain_pkg::CANCEL_HOLD_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[4:2])
                curtain_pkg::REG_CONTROL_TIME: control_time_reg <= pwdata[15:0];
                curtain_pkg::REG_ACTION_TIME:  action_time_reg  <= pwdata[16:0];
                curtain_pkg::REG_EXT_INVERT:   ext_invert_reg   <= pwdata[0];
                curtain_pkg::REG_POLL:         poll_reg         <= pwdata[7:0];
                curtain_pkg::REG_START_HOLD:   start_hold_reg   <= pwdata[9:0];
                curtain_pkg::REG_STOP_GAP:     stop_gap_reg     <= pwdata[9:0];
                curtain_pkg::REG_FULL_HOLD:    full_hold_reg    <= pwdata[11:0];
                curtain_pkg::REG_CANCEL_HOLD:  cancel_hold_reg  <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    // Register readback.
    always_comb
    begin
        case (paddr[4:2])
            curtain_pkg::REG_CONTROL_TIME: prdata = {16'd0, control_time_reg};
            curtain_pkg::REG_ACTION_TIME:  prdata = {15'd0, action_time_reg};
            curtain_pkg::REG_EXT_INVERT:   prdata = {31'd0, ext_invert_reg};
            curtain_pkg::REG_POLL:         prdata = {24'd0, poll_reg};
            curtain_pkg::REG_START_HOLD:   prdata = {22'd0, start_hold_reg};
            curtain_pkg::REG_STOP_GAP:     prdata = {22'd0, stop_gap_reg};
            curtain_pkg::REG_FULL_HOLD:    prdata = {20'd0, full_hold_reg};
            curtain_pkg::REG_CANCEL_HOLD:  prdata = {20'd0, cancel_hold_reg};
            default:                       prdata = 32'd0;
        endcase
    end

    // Saturating elapsed timer and the two limit compares.
    assign elapsed_inc   = (elapsed_reg == {TIMER_WIDTH{1'b1}})
                           ? elapsed_reg
                           : elapsed_reg + TIMER_WIDTH'(1);
    assign elapsed_cmp   = CMP_W'(elapsed_inc);
    assign timed_out     = elapsed_cmp > CMP_W'(action_time_reg);
    assign held_too_long = elapsed_cmp > CMP_W'(control_time_reg);
    assign full_drive    = (mode_reg == curtain_pkg::MODE_FULL_OPEN) ? curtain_pkg::RELAY_OPEN
                                                                     : curtain_pkg::RELAY_CLOSE;

    // Tick update: stop gap first, then the hold countdown, else evaluate inputs.
    always_comb
    begin
        mode_next    = mode_reg;
        elapsed_next = elapsed_inc;
        hold_next    = hold_reg;
        gap_next     = gap_reg;
        relay_next   = relay_reg;

        if (gap_reg != 10'd0)
        begin
            gap_next = gap_reg - 10'd1;
            if (gap_reg == 10'd1)
            begin
                relay_next = full_drive;
            end
        end
        else if (hold_reg != 12'd0)
        begin
            hold_next = hold_reg - 12'd1;
        end
        else
        begin
            case (mode_reg)
                curtain_pkg::MODE_WAIT:
                begin
                    if (!tick.man_open)
                    begin
                        mode_next    = curtain_pkg::MODE_OPEN;
                        relay_next   = curtain_pkg::RELAY_OPEN;
                        elapsed_next = '0;
                        hold_next    = curtain_pkg::wait_load({2'd0, start_hold_reg}, poll_reg);
                    end
                    else if (!tick.man_close)
                    begin
                        mode_next    = curtain_pkg::MODE_CLOSE;
                        relay_next   = curtain_pkg::RELAY_CLOSE;
                        elapsed_next = '0;
                        hold_next    = curtain_pkg::wait_load({2'd0, start_hold_reg}, poll_reg);
                    end
                    else if (tick.ext_open == ext_invert_reg)
                    begin
                        mode_next    = curtain_pkg::MODE_EXT_OPEN;
                        relay_next   = curtain_pkg::RELAY_OPEN;
                        elapsed_next = '0;
                        hold_next    = curtain_pkg::wait_load({2'd0, start_hold_reg}, poll_reg);
                    end
                    else if (tick.ext_close == ext_invert_reg)
                    begin
                        mode_next    = curtain_pkg::MODE_EXT_CLOSE;
                        relay_next   = curtain_pkg::RELAY_CLOSE;
                        elapsed_next = '0;
                        hold_next    = curtain_pkg::wait_load({2'd0, start_hold_reg}, poll_reg);
                    end
                    else
                    begin
                        hold_next = curtain_pkg::wait_load(12'd0, poll_reg);
                    end
                end
                curtain_pkg::MODE_OPEN, curtain_pkg::MODE_CLOSE:
                begin
                    // Button released stops; held long enough goes to full travel.
                    if ((mode_reg == curtain_pkg::MODE_OPEN) ? tick.man_open
                                                             : tick.man_close)
                    begin
                        mode_next  = curtain_pkg::MODE_WAIT;
                        relay_next = curtain_pkg::RELAY_STOP;
                        hold_next  = curtain_pkg::wait_load(12'd0, poll_reg);
                    end
                    else if (held_too_long)
                    begin
                        mode_next    = mode_reg + 3'd2;
                        elapsed_next = '0;
                        gap_next     = stop_gap_reg;
                        hold_next    = curtain_pkg::wait_load(full_hold_reg, poll_reg);
                        if (stop_gap_reg == 10'd0)
                        begin
                            relay_next = (mode_reg == curtain_pkg::MODE_OPEN)
                                         ? curtain_pkg::RELAY_OPEN
                                         : curtain_pkg::RELAY_CLOSE;
                        end
                        else
                        begin
                            relay_next = curtain_pkg::RELAY_STOP;
                        end
                    end
                    else
                    begin
                        hold_next = curtain_pkg::wait_load(12'd0, poll_reg);
                    end
                end
                curtain_pkg::MODE_FULL_OPEN, curtain_pkg::MODE_FULL_CLOSE:
                begin
                    // Any manual press cancels full travel with a longer hold.
                    if (!tick.man_open || !tick.man_close)
                    begin
                        mode_next  = curtain_pkg::MODE_WAIT;
                        relay_next = curtain_pkg::RELAY_STOP;
                        hold_next  = curtain_pkg::wait_load(cancel_hold_reg, poll_reg);
                    end
                    else if (timed_out)
                    begin
                        mode_next  = curtain_pkg::MODE_WAIT;
                        relay_next = curtain_pkg::RELAY_STOP;
                        hold_next  = curtain_pkg::wait_load(12'd0, poll_reg);
                    end
                    else
                    begin
                        hold_next = curtain_pkg::wait_load(12'd0, poll_reg);
                    end
                end
                curtain_pkg::MODE_EXT_OPEN, curtain_pkg::MODE_EXT_CLOSE:
                begin
                    // External modes follow their request level until it goes inactive or the action time runs out.
                    if ((((mode_reg == curtain_pkg::MODE_EXT_OPEN) ? tick.ext_open
                                                                    : tick.ext_close)
                         != ext_invert_reg) || timed_out)
                    begin
                        mode_next  = curtain_pkg::MODE_WAIT;
                        relay_next = curtain_pkg::RELAY_STOP;
                    end
                    hold_next = curtain_pkg::wait_load(12'd0, poll_reg);
                end
                default:
                begin
                    mode_next  = curtain_pkg::MODE_WAIT;
                    relay_next = curtain_pkg::RELAY_STOP;
                    hold_next  = curtain_pkg::wait_load(12'd0, poll_reg);
                end
            endcase
        end
    end

    // State registers advance once per accepted tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= curtain_pkg::MODE_WAIT;
            elapsed_reg <= '0;
            hold_reg    <= 12'd0;
            gap_reg     <= 10'd0;
            relay_reg   <= curtain_pkg::RELAY_STOP;
        end
        else if (accept)
        begin
            mode_reg    <= mode_next;
            elapsed_reg <= elapsed_next;
            hold_reg    <= hold_next;
            gap_reg     <= gap_next;
            relay_reg   <= relay_next;
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= {3'd0, mode_next, relay_next[1], relay_next[0]};
        end
    end

    // The stop gap only runs in full travel, with both relays stopped.
    assert property (@(posedge clk) disable iff (!rst_n)
        (gap_reg != 10'd0) |-> (mode_reg == curtain_pkg::MODE_FULL_OPEN ||
                                mode_reg == curtain_pkg::MODE_FULL_CLOSE))
        else $error("stop gap running outside full travel");

    assert property (@(posedge clk) disable iff (!rst_n)
        (gap_reg != 10'd0) |-> (relay_reg == curtain_pkg::RELAY_STOP))
        else $error("relays driven during stop gap");

    // Every accepted tick leaves a result in the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted tick produced no result");

    // Countdowns only move on accepted ticks.
    assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> ($stable(hold_reg) && $stable(gap_reg) && $stable(mode_reg)))
        else $error("state changed without a tick");

    // Starting a movement from wait restarts the elapsed timer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mode_reg == curtain_pkg::MODE_WAIT &&
         mode_next != curtain_pkg::MODE_WAIT) |=> (elapsed_reg == '0))
        else $error("elapsed timer not cleared at movement start");

endmodule

### tb/curtain_relay_controller_tb.sv
// ----------------------------------------------------------------------------
// Curtain relay controller testbench
// Streams one-millisecond tick requests into the controller and checks every
// result against a cycle-free prediction of relays and mode. The register
// settings change between phases, ranging from the lowest values to the largest.
// ----------------------------------------------------------------------------
module curtain_relay_controller_tb;

    localparam int TIMER_BITS  = 17;
    localparam int QUIET_LIMIT = 2000;

    // Expected result of one tick, laid out as on the result stream.
    typedef struct packed {
        logic [2:0] mode_code;
        logic       relay_two;
        logic       relay_one;
    } relay_view_t;

    // Receiver behaviors, switched at random intervals.
    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_ONE_IN_THREE,
        READY_MOSTLY
    } ready_style_e;

    // Kinds of input runs used by the random traffic.
    typedef enum int {
        RUN_IDLE,
        RUN_OPEN,
        RUN_CLOSE,
        RUN_EXT_OPEN,
        RUN_EXT_CLOSE,
        RUN_BOTH_MANUAL,
        RUN_NOISE
    } run_kind_e;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;  // [0] man open, [1] man close, [2] ext open, [3] ext close
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;           // [0] relay one, [1] relay two, [4:2] mode code
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [4:0]  paddr         = 5'd0;
    logic [31:0] pwdata        = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // Pending tick levels and the relay results they should produce.
    logic [3:0]  tick_q[$];
    relay_view_t relay_forecast_q[$];

    // Register shadow and controller state as predicted.
    logic [31:0]           cfg [8];
    logic [2:0]            mode_now   = curtain_pkg::MODE_WAIT;
    logic [TIMER_BITS-1:0] elapsed_ms = '0;
    logic [11:0]           hold_ms    = '0;
    logic [9:0]            gap_ms     = '0;
    logic [1:0]            relays_now = curtain_pkg::RELAY_STOP;

    int           ticks_sent       = 0;
    int           results_checked  = 0;
    int           settings_applied = 0;
    int           mismatches       = 0;
    int           quiet_cycles     = 0;
    int           burst_left       = 0;
    int           pause_left       = 0;
    int           style_left       = 0;
    int           style_cycle      = 0;
    ready_style_e style            = READY_ALWAYS;
    logic [7:0]   modes_reached    = 8'h00;

    curtain_relay_controller #(
        .TIMER_WIDTH(TIMER_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 clk = ~clk;

    // Implemented bits of each register.
    function automatic logic [31:0] reg_mask(input logic [2:0] idx);
        case (idx)
            curtain_pkg::REG_CONTROL_TIME: reg_mask = 32'h0000_FFFF;
            curtain_pkg::REG_ACTION_TIME:  reg_mask = 32'h0001_FFFF;
            curtain_pkg::REG_EXT_INVERT:   reg_mask = 32'h0000_0001;
            curtain_pkg::REG_POLL:         reg_mask = 32'h0000_00FF;
            curtain_pkg::REG_START_HOLD:   reg_mask = 32'h0000_03FF;
            curtain_pkg::REG_STOP_GAP:     reg_mask = 32'h0000_03FF;
            default:                       reg_mask = 32'h0000_0FFF;
        endcase
    endfunction

    // Countdown for a wait of the poll period plus an extra delay.
    function automatic logic [11:0] hold_count(input int extra);
        int total;
        total = extra + int'(cfg[curtain_pkg::REG_POLL]);
        if (total == 0)
            hold_count = '0;
        else if (total - 1 > 4095)
            hold_count = curtain_pkg::HOLD_MAX;
        else
            hold_count = 12'(total - 1);
    endfunction

    function automatic void begin_travel(input logic [2:0] m, input logic [1:0] relays);
        mode_now   = m;
        elapsed_ms = '0;
        relays_now = relays;
        hold_ms    = hold_count(int'(cfg[curtain_pkg::REG_START_HOLD]));
    endfunction

    function automatic void stop_motor(input int extra);
        mode_now   = curtain_pkg::MODE_WAIT;
        relays_now = curtain_pkg::RELAY_STOP;
        hold_ms    = hold_count(extra);
    endfunction

    // One tick of the controller: timers first, then input evaluation when
    // neither the stop gap nor the hold is running.
    function automatic relay_view_t advance_curtain_tick(input logic [3:0] levels);
        curtain_pkg::tick_in_t pins_in;
        logic                  timed_out;
        logic                  level;
        logic                  on;
        relay_view_t           view;
        pins_in = curtain_pkg::tick_in_t'(levels);
        on      = cfg[curtain_pkg::REG_EXT_INVERT][0];
        if (elapsed_ms != {TIMER_BITS{1'b1}})
            elapsed_ms = elapsed_ms + TIMER_BITS'(1);
        timed_out = elapsed_ms > cfg[curtain_pkg::REG_ACTION_TIME];

        if (gap_ms != 0)
        begin
            gap_ms = gap_ms - 10'd1;
            if (gap_ms == 0)
                relays_now = (mode_now == curtain_pkg::MODE_FULL_OPEN)
                             ? curtain_pkg::RELAY_OPEN : curtain_pkg::RELAY_CLOSE;
        end
        else if (hold_ms != 0)
        begin
            hold_ms = hold_ms - 12'd1;
        end
        else
        begin
            case (mode_now)
                curtain_pkg::MODE_WAIT:
                begin
                    if (!pins_in.man_open)
                        begin_travel(curtain_pkg::MODE_OPEN, curtain_pkg::RELAY_OPEN);
                    else if (!pins_in.man_close)
                        begin_travel(curtain_pkg::MODE_CLOSE, curtain_pkg::RELAY_CLOSE);
                    else if (pins_in.ext_open == on)
                        begin_travel(curtain_pkg::MODE_EXT_OPEN, curtain_pkg::RELAY_OPEN);
                    else if (pins_in.ext_close == on)
                        begin_travel(curtain_pkg::MODE_EXT_CLOSE, curtain_pkg::RELAY_CLOSE);
                    else
                        hold_ms = hold_count(0);
                end
                curtain_pkg::MODE_OPEN, curtain_pkg::MODE_CLOSE:
                begin
                    level = (mode_now == curtain_pkg::MODE_OPEN) ? pins_in.man_open
                                                                 : pins_in.man_close;
                    if (level)
                    begin
                        stop_motor(0);
                    end
                    else if (elapsed_ms > cfg[curtain_pkg::REG_CONTROL_TIME])
                    begin
                        // Long press: stop for the gap, then drive full travel.
                        mode_now   = (mode_now == curtain_pkg::MODE_OPEN)
                                     ? curtain_pkg::MODE_FULL_OPEN
                                     : curtain_pkg::MODE_FULL_CLOSE;
                        elapsed_ms = '0;
                        relays_now = curtain_pkg::RELAY_STOP;
                        gap_ms     = cfg[curtain_pkg::REG_STOP_GAP][9:0];
                        hold_ms    = hold_count(int'(cfg[curtain_pkg::REG_FULL_HOLD]));
                        if (gap_ms == 0)
                            relays_now = (mode_now == curtain_pkg::MODE_FULL_OPEN)
                                         ? curtain_pkg::RELAY_OPEN
                                         : curtain_pkg::RELAY_CLOSE;
                    end
                    else
                    begin
                        hold_ms = hold_count(0);
                    end
                end
                curtain_pkg::MODE_FULL_OPEN, curtain_pkg::MODE_FULL_CLOSE:
                begin
                    if (!pins_in.man_open || !pins_in.man_close)
                        stop_motor(int'(cfg[curtain_pkg::REG_CANCEL_HOLD]));
                    else if (timed_out)
                        stop_motor(0);
                    else
                        hold_ms = hold_count(0);
                end
                curtain_pkg::MODE_EXT_OPEN, curtain_pkg::MODE_EXT_CLOSE:
                begin
                    level = (mode_now == curtain_pkg::MODE_EXT_OPEN) ? pins_in.ext_open
                                                                     : pins_in.ext_close;
                    if (level != on || timed_out)
                        stop_motor(0);
                    else
                        hold_ms = hold_count(0);
                end
                default:
                begin
                    stop_motor(0);
                end
            endcase
        end

        view.mode_code = mode_now;
        view.relay_two = relays_now[1];
        view.relay_one = relays_now[0];
        return view;
    endfunction

    // Tick levels packed as on the input stream.
    function automatic logic [3:0] pins(input logic mo, input logic mc,
                                        input logic eo, input logic ec);
        pins = {ec, eo, mc, mo};
    endfunction

    task automatic push_run(input logic [3:0] levels, input int count);
        repeat (count) tick_q.push_back(levels);
    endtask

    task automatic apb_write(input logic [2:0] idx, input int value);
        logic [31:0] word;
        // Bits above the register width carry junk that must be dropped.
        word = 32'(value) | ($urandom & ~reg_mask(idx));
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        cfg[idx] = word & reg_mask(idx);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read(input logic [2:0] idx);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== cfg[idx])
        begin
            $error("register %0d readback: expected 0x%0h, got 0x%0h", idx, cfg[idx], prdata);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_settings();
        logic [3:0] r;
        for (r = 0; r < 8; r++)
            apb_read(r[2:0]);
    endtask

    task automatic apply_settings(input int ctl, input int act, input int inv,
                                  input int poll, input int start, input int gap,
                                  input int full, input int cancel);
        apb_write(curtain_pkg::REG_CONTROL_TIME, ctl);
        apb_write(curtain_pkg::REG_ACTION_TIME, act);
        apb_write(curtain_pkg::REG_EXT_INVERT, inv);
        apb_write(curtain_pkg::REG_POLL, poll);
        apb_write(curtain_pkg::REG_START_HOLD, start);
        apb_write(curtain_pkg::REG_STOP_GAP, gap);
        apb_write(curtain_pkg::REG_FULL_HOLD, full);
        apb_write(curtain_pkg::REG_CANCEL_HOLD, cancel);
        check_settings();
        settings_applied++;
    endtask

    // Runs of held buttons and external levels with sparse glitches, mixed
    // with short stretches of fully random levels.
    task automatic random_traffic(input int count);
        int          sent;
        int          run_len;
        int          pick;
        int          flip;
        logic        on;
        logic [3:0]  base;
        logic [3:0]  lv;
        run_kind_e   kind;
        sent = 0;
        while (sent < count)
        begin
            on      = cfg[curtain_pkg::REG_EXT_INVERT][0];
            pick    = $urandom_range(0, 7);
            kind    = (pick > RUN_NOISE) ? RUN_NOISE : run_kind_e'(pick);
            run_len = (kind == RUN_NOISE) ? $urandom_range(1, 6) : $urandom_range(1, 25);
            case (kind)
                RUN_IDLE:        base = pins(1'b1, 1'b1, ~on, ~on);
                RUN_OPEN:        base = pins(1'b0, 1'b1, ~on, ~on);
                RUN_CLOSE:       base = pins(1'b1, 1'b0, ~on, ~on);
                RUN_EXT_OPEN:    base = pins(1'b1, 1'b1, on, ~on);
                RUN_EXT_CLOSE:   base = pins(1'b1, 1'b1, ~on, on);
                RUN_BOTH_MANUAL: base = pins(1'b0, 1'b0, ~on, ~on);
                default:         base = 4'h0;
            endcase
            repeat (run_len)
            begin
                if (kind == RUN_NOISE)
                begin
                    lv = 4'($urandom_range(0, 15));
                end
                else
                begin
                    lv = base;
                    if ($urandom_range(0, 15) == 0)
                    begin
                        flip     = $urandom_range(0, 3);
                        lv[flip] = ~lv[flip];
                    end
                end
                if (sent < count)
                begin
                    tick_q.push_back(lv);
                    sent++;
                end
            end
        end
    endtask

    // Wait until every queued tick has gone through and been checked; the
    // check sits between edges so all updates of the last edge are visible.
    task automatic settle();
        do @(negedge clk);
        while (tick_q.size() != 0 || s_axis_tvalid || m_axis_tvalid
               || relay_forecast_q.size() != 0);
        repeat (2) @(posedge clk);
    endtask

    // Tick sender: bursts of random length with random pauses between them.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                relay_forecast_q.push_back(advance_curtain_tick(s_axis_tdata[3:0]));
                ticks_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pause_left > 0)
                begin
                    pause_left--;
                    s_axis_tvalid <= 1'b0;
                    s_axis_tdata  <= 8'($urandom_range(0, 15));
                end
                else if (tick_q.size() != 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {4'h0, tick_q.pop_front()};
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(0, 40);
                        pause_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: the ready pattern changes at random intervals.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (style_left == 0)
            begin
                style      = ready_style_e'($urandom_range(0, 3));
                style_left = $urandom_range(16, 160);
            end
            else
            begin
                style_left--;
            end
            style_cycle++;
            case (style)
                READY_ALWAYS:       m_axis_tready <= 1'b1;
                READY_COIN:         m_axis_tready <= ($urandom_range(0, 1) != 0);
                READY_ONE_IN_THREE: m_axis_tready <= (style_cycle % 3 == 0);
                default:            m_axis_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Result checker: each result against the oldest forecast.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_checked++;
            modes_reached[m_axis_tdata[4:2]] = 1'b1;
            if (relay_forecast_q.size() == 0)
            begin
                $error("result 0x%0h arrived with no tick request pending", m_axis_tdata);
                mismatches++;
            end
            else
            begin
                automatic relay_view_t exp_view = relay_forecast_q.pop_front();
                if (m_axis_tdata[0] !== exp_view.relay_one)
                begin
                    $error("relay_one: expected %0d, got %0d", exp_view.relay_one, m_axis_tdata[0]);
                    mismatches++;
                end
                if (m_axis_tdata[1] !== exp_view.relay_two)
                begin
                    $error("relay_two: expected %0d, got %0d", exp_view.relay_two, m_axis_tdata[1]);
                    mismatches++;
                end
                if (m_axis_tdata[4:2] !== exp_view.mode_code)
                begin
                    $error("mode_code: expected %0d, got %0d", exp_view.mode_code,
                           m_axis_tdata[4:2]);
                    mismatches++;
                end
                if (m_axis_tdata[7:5] !== 3'b000)
                begin
                    $error("tdata padding: expected 0, got %0d", m_axis_tdata[7:5]);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: ends the run when no transfer of any kind happens for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (psel && penable && pready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Watchdog: no transfer for %0d cycles.", QUIET_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Test sequence.
    initial
    begin
        cfg[curtain_pkg::REG_CONTROL_TIME] = 32'(curtain_pkg::CONTROL_TIME_RST);
        cfg[curtain_pkg::REG_ACTION_TIME]  = 32'(curtain_pkg::ACTION_TIME_RST);
        cfg[curtain_pkg::REG_EXT_INVERT]   = 32'(curtain_pkg::EXT_INVERT_RST);
        cfg[curtain_pkg::REG_POLL]         = 32'(curtain_pkg::POLL_RST);
        cfg[curtain_pkg::REG_START_HOLD]   = 32'(curtain_pkg::START_HOLD_RST);
        cfg[curtain_pkg::REG_STOP_GAP]     = 32'(curtain_pkg::STOP_GAP_RST);
        cfg[curtain_pkg::REG_FULL_HOLD]    = 32'(curtain_pkg::FULL_HOLD_RST);
        cfg[curtain_pkg::REG_CANCEL_HOLD]  = 32'(curtain_pkg::CANCEL_HOLD_RST);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Register values straight out of reset.
        check_settings();

        // Directed walk with every tick evaluated and short control and action times.
        apply_settings(2, 5, 1, 0, 0, 0, 0, 0);
        push_run(pins(1'b1, 1'b1, 1'b0, 1'b0), 1);   // nothing requested
        push_run(pins(1'b0, 1'b1, 1'b0, 1'b0), 1);   // open press starts a move
        push_run(pins(1'b1, 1'b1, 1'b0, 1'b0), 1);   // early release stops it
        push_run(pins(1'b0, 1'b0, 1'b0, 1'b0), 1);   // both buttons: open wins
        push_run(pins(1'b0, 1'b1, 1'b0, 1'b0), 3);   // held past control time
        push_run(pins(1'b1, 1'b1, 1'b0, 1'b0), 6);   // full open runs into timeout
        push_run(pins(1'b1, 1'b0, 1'b0, 1'b0), 5);   // full close, cancelled by press
        push_run(pins(1'b1, 1'b1, 1'b1, 1'b0), 2);   // external open follows level
        push_run(pins(1'b1, 1'b1, 1'b0, 1'b0), 1);
        push_run(pins(1'b1, 1'b1, 1'b0, 1'b1), 7);   // external close hits timeout
        push_run(pins(1'b1, 1'b1, 1'b1, 1'b1), 1);   // both external: open wins
        push_run(pins(1'b1, 1'b1, 1'b0, 1'b0), 1);
        settle();

        // Short holds, a stop gap and an active-low external level.
        apply_settings(4, 20, 0, 1, 0, 2, 1, 3);
        random_traffic(180);
        settle();

        // Lowest values: full travel and timeout right away.
        apply_settings(0, 0, 1, 0, 0, 0, 0, 0);
        random_traffic(150);
        settle();

        // Random short timings.
        repeat (3)
        begin
            apply_settings($urandom_range(0, 10), $urandom_range(0, 40), $urandom_range(0, 1),
                           $urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 4),
                           $urandom_range(0, 4), $urandom_range(0, 5));
            random_traffic(160);
            settle();
        end

        // Longest stop gap with a full-drive hold past the countdown range.
        apply_settings(0, 131071, 0, 2, 0, 1023, 4095, 4095);
        random_traffic(60);
        settle();

        // Largest values on every register.
        apply_settings(65535, 131071, 1, 255, 1023, 1023, 4095, 4095);
        random_traffic(60);
        settle();

        $display("Summary: %0d tick requests and %0d results checked over %0d register settings.",
                 ticks_sent, results_checked, settings_applied);
        $display("Summary: %0d of 7 modes seen on the result stream.", $countones(modes_reached));
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
